// ===== rtl/multichannel_phase_unwrap_assert.svh =====
// Assertion macros for the multichannel phase unwrapper.
// Used by the top level; expects signals named clock and reset in scope.
`ifndef MULTICHANNEL_PHASE_UNWRAP_ASSERT_SVH
`define MULTICHANNEL_PHASE_UNWRAP_ASSERT_SVH

// Condition that must hold at every edge outside reset.
`define MPU_CHECK_ALWAYS(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Trigger at one edge implies the outcome at the next edge.
`define MPU_CHECK_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) else $error(msg);

`endif

// ===== rtl/mpu_pkg.sv =====
// Shared constants, register codes and word types of the phase unwrapper.
// No dependencies; imported by every module of the block.
`default_nettype none

package mpu_pkg;

   localparam int CHAN_W      = 2;
   localparam int CHANNELS    = 1 << CHAN_W;
   localparam int PHASE_W     = 32;
   localparam int TOL_W       = 31;
   localparam int BLOCK_STEPS = 64;
   localparam int STEP_W      = $clog2(BLOCK_STEPS);
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 32;

   localparam logic [TOL_W-1:0] TOL_RESET    = 31'd205887;
   localparam logic             ENABLE_RESET = 1'b1;

   // 2*pi in Q16.16
   localparam int                CONST_W  = 19;
   localparam logic [CONST_W-1:0] TWO_PI_Q = 19'd411775;

   // jump magnitude, reciprocal multiply, quotient, product and correction widths
   localparam int MAG_W       = PHASE_W + 1;
   localparam int RECIP_SHIFT = 45;
   localparam int RECIP_W     = 27;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'((64'd1 << RECIP_SHIFT) / 64'(TWO_PI_Q));
   localparam int QUO_W  = 14;
   localparam int PROD_W = MAG_W;
   localparam int CORR_W = PROD_W + 1;
   localparam int WIDE_W = CORR_W + 1;

   localparam logic [CORR_W-1:0] TWO_PI_X1 = CORR_W'(TWO_PI_Q);
   localparam logic [CORR_W-1:0] TWO_PI_X2 = CORR_W'(64'(TWO_PI_Q) * 64'd2);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_TOLERANCE = 2'd0,
      REG_ENABLE    = 2'd1
   } csr_reg_type;

   typedef struct packed {
      logic [CHAN_W-1:0]         channel;
      logic signed [PHASE_W-1:0] phase;
      logic                      wr;      // update last phase of this channel
      logic                      unwrap;  // correction allowed (enabled, not step 0)
   } item_type;

   typedef struct packed {
      logic [CHAN_W-1:0]         channel;
      logic signed [PHASE_W-1:0] phase;
      logic                      wr;
      logic                      fix;     // jump exceeded tolerance
      logic                      neg;     // sample below last phase
   } carry_type;

   typedef struct packed {
      logic [CHAN_W-1:0]         channel;
      logic signed [PHASE_W-1:0] phase;
      logic                      wr;
   } result_type;

endpackage

`default_nettype wire

// ===== rtl/mpu_phase_mem.sv =====
// Last-phase store: one entry per channel, registered read, per-entry valid bits.
// Depends on mpu_pkg.
`default_nettype none

module mpu_phase_mem import mpu_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      rd_en,
   input  logic [CHAN_W-1:0]         rd_addr,
   output logic signed [PHASE_W-1:0] rd_data,
   input  logic                      wr_en,
   input  logic [CHAN_W-1:0]         wr_addr,
   input  logic signed [PHASE_W-1:0] wr_data
);

   logic signed [PHASE_W-1:0] phase_mem [CHANNELS];
   logic [CHANNELS-1:0]       vld_ff;
   logic [CHANNELS-1:0]       vld_in;
   logic signed [PHASE_W-1:0] q_ff;
   logic                      qv_ff;

   always_comb begin
      vld_in = vld_ff;
      if (wr_en) begin
         vld_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         qv_ff  <= 1'b0;
      end else begin
         vld_ff <= vld_in;
         if (rd_en) begin
            qv_ff <= vld_ff[rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         phase_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         q_ff <= phase_mem[rd_addr];
      end
   end

   // never-written entries read as the reset value, zero
   assign rd_data = qv_ff ? q_ff : '0;

endmodule

`default_nettype wire

// ===== rtl/mpu_corr_pipe.sv =====
// Five-stage correction pipeline: jump, reciprocal quotient, product,
// correction, then add/subtract with clamp. Depends on mpu_pkg.
`default_nettype none

module mpu_corr_pipe import mpu_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  item_type                  in_item,
   output logic                      in_ready,
   input  logic signed [PHASE_W-1:0] prev_phase,
   input  logic [TOL_W-1:0]          tolerance,
   input  logic                      out_ready,
   output logic                      out_valid,
   output result_type                out_result,
   output logic [CHANNELS-1:0]       busy
);

   logic                s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff, s5_vld_ff;
   logic                rdy1, rdy2, rdy3, rdy4, rdy5;
   item_type            s1_item_ff;
   carry_type           s2_ctl_ff, s3_ctl_ff, s4_ctl_ff, s5_ctl_ff;
   carry_type           s2_ctl_in;
   logic [MAG_W-1:0]    s2_mag_ff, s3_mag_ff, s4_mag_ff;
   logic [QUO_W-1:0]    s3_quo_ff;
   logic [PROD_W-1:0]   s4_prod_ff;
   logic [CORR_W-1:0]   s5_corr_ff;

   logic [MAG_W-1:0]          jump;
   logic [MAG_W-1:0]          mag;
   logic                      over;
   logic [MAG_W+RECIP_W-1:0]  quo_full;
   logic [PROD_W-1:0]         prod;
   logic [CORR_W-1:0]         corr1, corr2;
   logic                      ge;
   logic signed [WIDE_W-1:0]  x_wide, corr_wide, sum;
   logic signed [PHASE_W-1:0] clamped;
   logic                      sat;

   assign rdy5     = !s5_vld_ff || out_ready;
   assign rdy4     = !s4_vld_ff || rdy5;
   assign rdy3     = !s3_vld_ff || rdy4;
   assign rdy2     = !s2_vld_ff || rdy3;
   assign rdy1     = !s1_vld_ff || rdy2;
   assign in_ready = rdy1;

   // jump against the stored phase and tolerance test
   always_comb begin
      jump = {s1_item_ff.phase[PHASE_W-1], s1_item_ff.phase}
           - {prev_phase[PHASE_W-1], prev_phase};
      mag  = jump[MAG_W-1] ? (~jump + MAG_W'(1)) : jump;
      over = mag > MAG_W'(tolerance);
      s2_ctl_in.channel = s1_item_ff.channel;
      s2_ctl_in.phase   = s1_item_ff.phase;
      s2_ctl_in.wr      = s1_item_ff.wr;
      s2_ctl_in.fix     = s1_item_ff.unwrap && over;
      s2_ctl_in.neg     = jump[MAG_W-1];
   end

   // quotient estimate, at most one below floor(mag / 2pi)
   assign quo_full = MAG_W'(s2_mag_ff) * (MAG_W+RECIP_W)'(RECIP);
   assign prod     = PROD_W'(s3_quo_ff) * PROD_W'(TWO_PI_Q);

   // correction (d+1)*2pi: bump the estimate when the remainder reaches 2pi
   always_comb begin
      corr1 = {1'b0, s4_prod_ff} + TWO_PI_X1;
      corr2 = {1'b0, s4_prod_ff} + TWO_PI_X2;
      ge    = {1'b0, s4_mag_ff} >= corr1;
   end

   // apply and clamp to Q16.16
   always_comb begin
      x_wide    = WIDE_W'(s5_ctl_ff.phase);
      corr_wide = $signed({1'b0, s5_corr_ff});
      sum       = s5_ctl_ff.neg ? (x_wide + corr_wide) : (x_wide - corr_wide);
      sat       = (sum[WIDE_W-1:PHASE_W-1] != '0) && (sum[WIDE_W-1:PHASE_W-1] != '1);
      if (sat) begin
         clamped = sum[WIDE_W-1] ? {1'b1, {(PHASE_W-1){1'b0}}}
                                 : {1'b0, {(PHASE_W-1){1'b1}}};
      end else begin
         clamped = sum[PHASE_W-1:0];
      end
      out_result.channel = s5_ctl_ff.channel;
      out_result.phase   = s5_ctl_ff.fix ? clamped : s5_ctl_ff.phase;
      out_result.wr      = s5_ctl_ff.wr;
   end

   assign out_valid = s5_vld_ff;

   // channels with a write-back still in flight
   always_comb begin
      busy = '0;
      if (s1_vld_ff && s1_item_ff.wr) busy[s1_item_ff.channel] = 1'b1;
      if (s2_vld_ff && s2_ctl_ff.wr)  busy[s2_ctl_ff.channel]  = 1'b1;
      if (s3_vld_ff && s3_ctl_ff.wr)  busy[s3_ctl_ff.channel]  = 1'b1;
      if (s4_vld_ff && s4_ctl_ff.wr)  busy[s4_ctl_ff.channel]  = 1'b1;
      if (s5_vld_ff && s5_ctl_ff.wr)  busy[s5_ctl_ff.channel]  = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
         s5_vld_ff <= 1'b0;
      end else begin
         if (rdy1) s1_vld_ff <= in_valid;
         if (rdy2) s2_vld_ff <= s1_vld_ff;
         if (rdy3) s3_vld_ff <= s2_vld_ff;
         if (rdy4) s4_vld_ff <= s3_vld_ff;
         if (rdy5) s5_vld_ff <= s4_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1 && in_valid) begin
         s1_item_ff <= in_item;
      end
      if (rdy2 && s1_vld_ff) begin
         s2_ctl_ff <= s2_ctl_in;
         s2_mag_ff <= mag;
      end
      if (rdy3 && s2_vld_ff) begin
         s3_ctl_ff <= s2_ctl_ff;
         s3_mag_ff <= s2_mag_ff;
         s3_quo_ff <= quo_full[RECIP_SHIFT +: QUO_W];
      end
      if (rdy4 && s3_vld_ff) begin
         s4_ctl_ff  <= s3_ctl_ff;
         s4_mag_ff  <= s3_mag_ff;
         s4_prod_ff <= prod;
      end
      if (rdy5 && s4_vld_ff) begin
         s5_ctl_ff  <= s4_ctl_ff;
         s5_corr_ff <= ge ? corr2 : corr1;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/multichannel_phase_unwrap.sv =====
// Top level of the multichannel phase unwrapper: handshakes, registers,
// step counter, hazard check and output register. Depends on mpu_pkg,
// mpu_phase_mem, mpu_corr_pipe and multichannel_phase_unwrap_assert.svh.
//
//   channel  direction  handshake            word
//   req_     in         req_valid/req_stall  channel, phase_in, step_end
//   rsp_     out        rsp_valid/rsp_stall  channel_out, phase_out
//   csr_     in         csr_valid/csr_ready  csr_index, csr_wdata
//
// rsp_valid rises once an accepted word has passed the memory read, which shares the
// first of five correction stages, and then the output register.
// One word per cycle across channels while req_stall is low; a word whose channel has an
// earlier write-back in flight holds until that word writes back.
// Synchronous reset clears control state and marks every last phase as zero.
// rsp_stall backs up the pipeline stage by stage and lengthens that hold.
`default_nettype none
`include "multichannel_phase_unwrap_assert.svh"

module multichannel_phase_unwrap import mpu_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [CHAN_W-1:0]            req_channel,
   input  logic signed [PHASE_W-1:0]    req_phase_in,
   input  logic                         req_step_end,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [CHAN_W-1:0]            rsp_channel_out,
   output logic signed [PHASE_W-1:0]    rsp_phase_out,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_wdata
);

   logic [TOL_W-1:0]          tolerance_ff, tolerance_in;
   logic                      enable_ff, enable_in;
   logic [STEP_W-1:0]         step_count_ff, step_count_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [CHAN_W-1:0]         rsp_channel_ff;
   logic signed [PHASE_W-1:0] rsp_phase_ff;

   logic                      req_fire;
   logic                      hazard;
   logic                      pipe_rdy;
   logic [CHANNELS-1:0]       busy;
   logic                      chan_ok;
   item_type                  item;
   logic signed [PHASE_W-1:0] prev_phase;
   logic                      res_valid;
   result_type                res;
   logic                      out_rdy;
   logic                      res_take;
   logic                      mem_wr_en;
   logic [CHAN_W-1:0]         mem_wr_addr;

   // ---------------- configuration ----------------
   assign csr_ready = 1'b1;

   always_comb begin
      tolerance_in = tolerance_ff;
      enable_in    = enable_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_TOLERANCE: tolerance_in = csr_wdata[TOL_W-1:0];
            REG_ENABLE:    enable_in    = csr_wdata[0];
            default:       ;  // drop writes to unknown registers
         endcase
      end
   end

   // ---------------- input side ----------------
   // Hold a word whose channel still has a write-back pending, so the
   // memory read always sees the latest last phase.
   assign hazard    = busy[req_channel];
   assign req_stall = !pipe_rdy || hazard;
   assign req_fire  = req_valid && !req_stall;

   assign chan_ok = (CHAN_W+1)'(req_channel) < (CHAN_W+1)'(CHANNELS);

   always_comb begin
      item.channel = req_channel;
      item.phase   = req_phase_in;
      item.wr      = enable_ff && chan_ok;
      item.unwrap  = enable_ff && chan_ok && (step_count_ff != '0);
   end

   // Advance the time-step counter on every accepted step end, enabled or not.
   always_comb begin
      step_count_in = step_count_ff;
      if (req_fire && req_step_end) begin
         if (step_count_ff == STEP_W'(BLOCK_STEPS - 1)) begin
            step_count_in = '0;
         end else begin
            step_count_in = step_count_ff + STEP_W'(1);
         end
      end
   end

   // ---------------- state memory and pipeline ----------------
   mpu_phase_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_fire),
      .rd_addr (req_channel),
      .rd_data (prev_phase),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (res.phase)
   );

   mpu_corr_pipe u_pipe (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_fire),
      .in_item    (item),
      .in_ready   (pipe_rdy),
      .prev_phase (prev_phase),
      .tolerance  (tolerance_ff),
      .out_ready  (out_rdy),
      .out_valid  (res_valid),
      .out_result (res),
      .busy       (busy)
   );

   // Write back the result as it leaves the pipeline.
   assign res_take    = res_valid && out_rdy;
   assign mem_wr_en   = res_take && res.wr;
   assign mem_wr_addr = res.channel;

   // ---------------- output register ----------------
   assign out_rdy = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_rdy) begin
         rsp_valid_in = res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tolerance_ff  <= TOL_RESET;
         enable_ff     <= ENABLE_RESET;
         step_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         tolerance_ff  <= tolerance_in;
         enable_ff     <= enable_in;
         step_count_ff <= step_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_take) begin
         rsp_channel_ff <= res.channel;
         rsp_phase_ff   <= res.phase;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_channel_out = rsp_channel_ff;
   assign rsp_phase_out   = rsp_phase_ff;

   // ---------------- checks ----------------
   `MPU_CHECK_ALWAYS(a_no_rw_clash, !(mem_wr_en && req_fire && (mem_wr_addr == req_channel)), "read of a channel during its own write-back")
   `MPU_CHECK_NEXT(a_pipe_hold, res_valid && !out_rdy, res_valid && $stable(res.phase), "pipeline result changed while blocked")
   `MPU_CHECK_NEXT(a_step_wrap, req_fire && req_step_end && (step_count_ff == STEP_W'(BLOCK_STEPS - 1)), step_count_ff == '0, "step counter did not wrap")

endmodule

`default_nettype wire

// ===== test/multichannel_phase_unwrap_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for multichannel_phase_unwrap: drives phase sample words and
// register writes, predicts every unwrapped word and compares it on the rsp_ side.
// Depends on mpu_pkg and the block's RTL only.

module multichannel_phase_unwrap_tb;
   import mpu_pkg::*;

   // 2*pi and pi in Q16.16, and the Q16.16 limits
   localparam longint TWO_PI_FIX = 64'sd411775;
   localparam longint HALF_TURN  = 64'sd205887;
   localparam longint Q_TOP      = 64'sd2147483647;
   localparam longint Q_BOTTOM   = -64'sd2147483648;

   localparam logic [TOL_W-1:0] TOL_AT_RESET = 31'd205887;

   // Register indexes that map to nothing
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_B = 2'd3;

   localparam int PIPE_LATENCY = 7;
   localparam int DRAIN_CYCLES = 2 * PIPE_LATENCY + 4;
   localparam int CYCLE_LIMIT  = 2000000;
   localparam int REPORT_LIMIT = 10;
   localparam int ROUNDS       = 6;
   localparam int ROUND_ITEMS  = 315;

   typedef struct packed {
      logic [CHAN_W-1:0]         channel;
      logic signed [PHASE_W-1:0] phase;
   } unwrapped_word_type;

   logic                      clock;
   logic                      reset        = 1'b1;
   logic                      req_valid    = 1'b0;
   logic                      req_stall;
   logic [CHAN_W-1:0]         req_channel  = '0;
   logic signed [PHASE_W-1:0] req_phase_in = '0;
   logic                      req_step_end = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall    = 1'b0;
   logic [CHAN_W-1:0]         rsp_channel_out;
   logic signed [PHASE_W-1:0] rsp_phase_out;
   logic                      csr_valid    = 1'b0;
   logic                      csr_ready;
   logic [CSR_IDX_W-1:0]      csr_index    = '0;
   logic [CSR_DATA_W-1:0]     csr_wdata    = '0;

   // Predictor state: registers, last phase per channel, step counter
   logic [TOL_W-1:0]          tol_reg   = TOL_AT_RESET;
   logic                      unwrap_on = 1'b1;
   logic signed [PHASE_W-1:0] chan_last [CHANNELS];
   logic [STEP_W-1:0]         step_idx  = '0;

   unwrapped_word_type unwrapped_q [$];
   longint             walk [CHANNELS];

   int  mismatch_count = 0;
   int  words_checked  = 0;
   int  samples_sent   = 0;
   int  csr_writes     = 0;
   int  cycle_count    = 0;
   int  stall_left     = 0;
   bit  steady_run     = 1'b0;

   multichannel_phase_unwrap u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_channel     (req_channel),
      .req_phase_in    (req_phase_in),
      .req_step_end    (req_step_end),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_channel_out (rsp_channel_out),
      .rsp_phase_out   (rsp_phase_out),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Mostly no gap, often a short one, now and then a long one
   function automatic int pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (steady_run) return 0;
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Work out the unwrapped word for one accepted sample and advance the state
   function automatic unwrapped_word_type unwrap_sample(input logic [CHAN_W-1:0] ch,
                                                        input logic signed [PHASE_W-1:0] x,
                                                        input logic se);
      unwrapped_word_type w;
      longint prev, jump, mag, turns, y;
      y = longint'(x);
      if (unwrap_on && step_idx != '0) begin
         prev = longint'(chan_last[ch]);
         jump = y - prev;
         mag  = (jump < 0) ? -jump : jump;
         // strictly greater than tolerance triggers the fix
         if (mag > longint'(tol_reg)) begin
            turns = mag / TWO_PI_FIX + 1;
            y = (jump >= 0) ? y - turns * TWO_PI_FIX : y + turns * TWO_PI_FIX;
            if (y > Q_TOP)
               y = Q_TOP;
            else if (y < Q_BOTTOM)
               y = Q_BOTTOM;
         end
      end
      if (unwrap_on)
         chan_last[ch] = y[PHASE_W-1:0];
      if (se)
         step_idx = step_idx + 1'b1;
      w.channel = ch;
      w.phase   = y[PHASE_W-1:0];
      return w;
   endfunction

   // Pick a phase for a channel: wrapped trajectory, near-tolerance jump,
   // multi-turn jump or raw noise
   function automatic logic signed [PHASE_W-1:0] next_sample(input logic [CHAN_W-1:0] ch);
      longint v, tol_l;
      int unsigned mode;
      mode  = $urandom_range(0, 99);
      tol_l = longint'(tol_reg);
      if ($urandom_range(0, 9) == 0)
         walk[ch] = walk[ch] + longint'($urandom_range(0, 800000)) - 400000;
      else
         walk[ch] = walk[ch] + longint'($urandom_range(0, 80000)) - 40000;
      v = walk[ch] % TWO_PI_FIX;
      if (v < 0)
         v = v + TWO_PI_FIX;
      v = v - HALF_TURN;
      if (mode < 15)
         v = longint'(chan_last[ch]) + (($urandom_range(0, 1) != 0) ? tol_l : -tol_l)
             + longint'($urandom_range(0, 2)) - 1;
      else if (mode < 30)
         v = v + (longint'($urandom_range(0, 10000)) - 5000) * TWO_PI_FIX;
      else if (mode < 40)
         v = longint'($urandom);
      return v[PHASE_W-1:0];
   endfunction

   // Offer one sample word, hold it until accepted, then log its prediction
   task automatic send_sample(input logic [CHAN_W-1:0] ch,
                              input logic signed [PHASE_W-1:0] ph,
                              input logic se);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid    <= 1'b1;
      req_channel  <= ch;
      req_phase_in <= ph;
      req_step_end <= se;
      do @(posedge clock); while (req_stall);
      unwrapped_q.push_back(unwrap_sample(ch, ph, se));
      samples_sent++;
   endtask

   // Drop valid and let every pending word come out
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (unwrapped_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write one register once the block is idle
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      wait_idle();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_TOLERANCE: tol_reg = data[TOL_W-1:0];
         REG_ENABLE:    unwrap_on = data[0];
         default: ;
      endcase
      csr_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic void log_mismatch(input string what, input unwrapped_word_type want);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("%s: expected ch %0d phase %0d (%08h), got ch %0d phase %0d (%08h)",
                  what, want.channel, want.phase, want.phase,
                  rsp_channel_out, rsp_phase_out, rsp_phase_out);
   endfunction

   // Compare each accepted result word with the oldest prediction
   always @(posedge clock) begin : check_words
      unwrapped_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         words_checked++;
         if (unwrapped_q.size() == 0) begin
            want = '0;
            log_mismatch("unexpected word", want);
         end else begin
            want = unwrapped_q.pop_front();
            if (rsp_channel_out !== want.channel || rsp_phase_out !== want.phase)
               log_mismatch("word mismatch", want);
         end
      end
   end

   // Back-pressure on the result side
   always @(negedge clock) begin
      if (stall_left == 0 && !reset)
         stall_left = pick_gap();
      rsp_stall <= (stall_left > 0);
      if (stall_left > 0)
         stall_left--;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("watchdog expired after %0d cycles, %0d words pending",
                  cycle_count, unwrapped_q.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Step 0 of a block: samples pass through and seed the last phases
   task automatic test_block_start();
      send_sample(2'd0, 32'sh7FFF_FFFF, 1'b0);
      send_sample(2'd1, 32'sh8000_0000, 1'b0);
      send_sample(2'd2, 32'sd1000, 1'b0);
      send_sample(2'd3, -32'sd1000, 1'b1);
   endtask

   // Jump equal to tolerance, just above it both ways, and saturation both ways
   task automatic test_tolerance_edge();
      send_sample(2'd2, 32'sd206887, 1'b0);
      send_sample(2'd2, 32'sd412775, 1'b0);
      send_sample(2'd3, -32'sd206888, 1'b0);
      send_sample(2'd0, 32'sh8000_0000, 1'b0);
      send_sample(2'd1, 32'sh7FFF_FFFF, 1'b1);
   endtask

   // Zero and full-scale tolerance; bit 31 of the write data must be dropped
   task automatic test_tolerance_extremes();
      write_reg(REG_TOLERANCE, 32'h8000_0000);
      send_sample(2'd2, chan_last[2] + 32'sd1, 1'b0);
      send_sample(2'd2, chan_last[2], 1'b0);
      write_reg(REG_TOLERANCE, 32'hFFFF_FFFF);
      send_sample(2'd0, 32'sh8000_0000, 1'b0);
      send_sample(2'd1, 32'sh7FFF_FFFF, 1'b0);
      send_sample(2'd3, 32'sd12345, 1'b1);
   endtask

   // Disabled: pass through, store frozen, step counter keeps running
   task automatic test_bypass();
      write_reg(REG_ENABLE, 32'hFFFF_FFFE);
      send_sample(2'd0, 32'sh5555_5555, 1'b1);
      send_sample(2'd1, 32'shAAAA_AAAA, 1'b1);
      send_sample(2'd2, 32'sh1234_5678, 1'b0);
      send_sample(2'd3, 32'sd0, 1'b1);
      write_reg(REG_ENABLE, 32'h0000_0001);
      write_reg(REG_TOLERANCE, {1'b0, TOL_AT_RESET});
      send_sample(2'd0, 32'sd300000, 1'b1);
   endtask

   // Writes to unmapped indexes change nothing
   task automatic test_spare_registers();
      write_reg(REG_SPARE_A, 32'h0000_0000);
      write_reg(REG_SPARE_B, 32'hFFFF_FFFF);
      send_sample(2'd1, 32'sd5000, 1'b1);
      send_sample(2'd2, 32'sd900000, 1'b0);
   endtask

   // Random words: mostly full time steps over all channels, some broken
   // steps and some raw noise
   task automatic stream_samples(input int n_items);
      int sent;
      int unsigned kind, burst;
      logic [CHAN_W-1:0] ch;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(0, 19) == 0)
            steady_run = ($urandom_range(0, 3) == 0);
         kind = $urandom_range(0, 99);
         if (kind < 75) begin
            for (int c = 0; c < CHANNELS; c++) begin
               ch = c[CHAN_W-1:0];
               send_sample(ch, next_sample(ch), c == CHANNELS - 1);
            end
            sent += CHANNELS;
         end else if (kind < 88) begin
            burst = $urandom_range(1, 3);
            repeat (burst) begin
               ch = CHAN_W'($urandom_range(0, CHANNELS - 1));
               send_sample(ch, next_sample(ch), 1'($urandom_range(0, 1)));
            end
            sent += burst;
         end else begin
            ch = CHAN_W'($urandom_range(0, CHANNELS - 1));
            send_sample(ch, $urandom, 1'($urandom_range(0, 1)));
            sent++;
         end
      end
      steady_run = 1'b0;
   endtask

   // Several register settings, extremes included, each with a random stream
   task automatic test_random_unwrap();
      logic [CSR_DATA_W-1:0] tol_word, en_word;
      for (int r = 0; r < ROUNDS; r++) begin
         en_word = $urandom;
         en_word[0] = (r != ROUNDS - 1);
         case (r)
            0: tol_word = {1'b0, TOL_AT_RESET};
            1: tol_word = 32'h8000_0000;
            2: tol_word = 32'h7FFF_FFFF;
            3: tol_word = $urandom_range(1, 600000);
            4: tol_word = $urandom;
            default: tol_word = $urandom_range(100000, 300000);
         endcase
         write_reg(REG_TOLERANCE, tol_word);
         write_reg(REG_ENABLE, en_word);
         stream_samples(ROUND_ITEMS);
      end
   endtask

   initial begin
      for (int k = 0; k < CHANNELS; k++) begin
         chan_last[k] = '0;
         walk[k] = 0;
      end
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_block_start();
      test_tolerance_edge();
      test_tolerance_extremes();
      test_bypass();
      test_spare_registers();
      test_random_unwrap();

      wait_idle();
      $display("Sent %0d phase samples over %0d register writes; %0d result words checked",
               samples_sent, csr_writes, words_checked);
      $display("Mismatches: %0d, words left pending: %0d", mismatch_count, unwrapped_q.size());
      if (mismatch_count == 0 && unwrapped_q.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
